### hw/rtl/arch128_pkg.sv
// shared types, constants and aes round helpers for the chunk hash core
// no dependencies
`default_nettype none

package arch128_pkg;

    localparam logic [63:0] SEED_CONST = 64'h1337133713371337;
    localparam logic [3:0]  LAST_WORD_POS = 4'd9;   // ten words per 80-byte chunk

    typedef logic [127:0] t_block;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_PAD,
        ST_DRAIN,
        ST_FIN
    } t_state;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

`default_nettype wire

### hw/rtl/arch128_round.sv
// one aes encryption round: subbytes, shiftrows, mixcolumns, key xor
// depends on arch128_pkg
`default_nettype none

module arch128_round (
    input  wire arch128_pkg::t_block i_state,
    input  wire arch128_pkg::t_block i_key,
    output arch128_pkg::t_block      o_result
);
    import arch128_pkg::*;

    logic [7:0] sr [16];
    t_block     mixed;

    // byte i of column c comes from column (c + i) mod 4
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                sr[i + 4 * c] = SBOX[i_state[8 * (i + 4 * ((c + i) % 4)) +: 8]];
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            mixed[32 * c +: 8]      = xtime(sr[4 * c]) ^ xtime(sr[4 * c + 1]) ^ sr[4 * c + 1]
                                      ^ sr[4 * c + 2] ^ sr[4 * c + 3];
            mixed[32 * c + 8 +: 8]  = sr[4 * c] ^ xtime(sr[4 * c + 1]) ^ xtime(sr[4 * c + 2])
                                      ^ sr[4 * c + 2] ^ sr[4 * c + 3];
            mixed[32 * c + 16 +: 8] = sr[4 * c] ^ sr[4 * c + 1] ^ xtime(sr[4 * c + 2])
                                      ^ xtime(sr[4 * c + 3]) ^ sr[4 * c + 3];
            mixed[32 * c + 24 +: 8] = xtime(sr[4 * c]) ^ sr[4 * c] ^ sr[4 * c + 1]
                                      ^ sr[4 * c + 2] ^ xtime(sr[4 * c + 3]);
        end
    end

    assign o_result = mixed ^ i_key;

endmodule

`default_nettype wire

### hw/rtl/aes_round_chunk_hash_128_core.sv
// top level of the aes round chunk hash core
// depends on arch128_pkg and arch128_round
`default_nettype none

// Streaming 128-bit hash. A message arrives as 64-bit little-endian words on
// the data channel, one word per cycle while a message streams; the first
// word of a message also carries its byte length (low LENGTH_BITS bits kept,
// at most the 32 bits of the port). Every two words form a 128-bit piece; the
// first piece of a chunk is loaded into a chunk accumulator and each later one
// is folded in by one aes round; after ten words the chunk is closed by two
// more rounds in a two-stage pipe behind the fold register, so words keep
// flowing. After the last word the core stops taking words while it pads the
// open chunk with zero words, lets the chunk pipe drain and runs four final
// rounds keyed by the seed on one round unit, the last of them only once the
// output register is free; the result then sits in the output register and
// the next message can start while it waits to be taken. A message of length
// zero takes one word, whose data is ignored, and gives its hash after the
// four final rounds.
module aes_round_chunk_hash_128_core #(
    parameter int LENGTH_BITS = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_data_valid,
    output logic        o_data_ready,
    input  wire  [63:0] i_data_word,
    input  wire  [31:0] i_message_length,
    output logic        o_hash_valid,
    input  wire         i_hash_ready,
    output logic [63:0] o_hash_low,
    output logic [63:0] o_hash_high
);
    import arch128_pkg::*;

    // the length port is 32 bits wide, so a wider setting keeps all of it
    localparam int LenW = (LENGTH_BITS < 32) ? LENGTH_BITS : 32;

    t_state          r_state, n_state;
    logic [LenW-1:0] r_remaining, n_remaining;
    logic [63:0]     r_seed_high, n_seed_high;
    t_block          r_hash, n_hash;
    t_block          r_fold, n_fold;
    logic [63:0]     r_half, n_half;
    logic [3:0]      r_wic, n_wic;
    logic            r_chunk_go, n_chunk_go;
    t_block          r_f2;
    logic            r_f2_v;
    logic [1:0]      r_fin_cnt, n_fin_cnt;
    logic            r_out_v, n_out_v;
    t_block          r_out, n_out;

    logic            accept, first, empty_msg, rem_ge8, absorb, out_free;
    logic [LenW-1:0] len, rem_eff;
    logic [63:0]     masked, abs_word, new_seed_high;
    t_block          seed, piece, fold_round, chunk_round, hash_key, hash_round;

    assign o_data_ready = (r_state == ST_RUN);
    assign accept       = i_data_valid && o_data_ready;
    assign first        = (r_remaining == '0);
    assign len          = i_message_length[LenW-1:0];
    assign empty_msg    = first && (len == '0);
    assign rem_eff      = first ? len : r_remaining;
    assign rem_ge8      = (rem_eff >= LenW'(8));
    assign seed         = {r_seed_high, SEED_CONST};
    assign new_seed_high = SEED_CONST + 64'(len) + 64'd1;
    assign out_free     = !r_out_v || i_hash_ready;

    // bytes past the message end read as zero
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            masked[8 * b +: 8] = (rem_ge8 || (3'(b) < rem_eff[2:0])) ?
                                 i_data_word[8 * b +: 8] : 8'h00;
        end
    end

    // padding absorbs zero words until the chunk closes
    assign absorb   = (accept && !empty_msg) || (r_state == ST_PAD && r_wic != '0);
    assign abs_word = (r_state == ST_PAD) ? 64'd0 : masked;
    assign piece    = {abs_word ^ r_seed_high, r_half ^ SEED_CONST};
    assign hash_key = r_f2_v ? r_f2 : seed;

    arch128_round u_fold_round (
        .i_state  (r_fold),
        .i_key    (piece),
        .o_result (fold_round)
    );

    arch128_round u_chunk_round (
        .i_state  (r_fold),
        .i_key    (seed),
        .o_result (chunk_round)
    );

    arch128_round u_hash_round (
        .i_state  (r_hash),
        .i_key    (hash_key),
        .o_result (hash_round)
    );

    always_comb begin
        n_state     = r_state;
        n_remaining = r_remaining;
        n_seed_high = r_seed_high;
        n_hash      = r_hash;
        n_fold      = r_fold;
        n_half      = r_half;
        n_wic       = r_wic;
        n_chunk_go  = 1'b0;
        n_fin_cnt   = r_fin_cnt;
        n_out_v     = r_out_v && !i_hash_ready;
        n_out       = r_out;

        // word absorb: even position stores a half, position one loads a piece, later odd positions fold one
        if (absorb) begin
            if (!r_wic[0]) begin
                n_half = abs_word;
            end else if (r_wic == 4'd1) begin
                n_fold = piece;
            end else begin
                n_fold = fold_round;
            end
            n_chunk_go = (r_wic == LAST_WORD_POS);
            n_wic      = (r_wic == LAST_WORD_POS) ? 4'd0 : r_wic + 4'd1;
        end

        // second stage of a closed chunk folds it into the running hash
        if (r_f2_v) begin
            n_hash = hash_round;
        end

        case (r_state)
            ST_RUN: begin
                if (accept) begin
                    if (first) begin
                        n_seed_high = new_seed_high;
                        n_hash      = {new_seed_high, SEED_CONST};
                    end
                    n_remaining = rem_ge8 ? rem_eff - LenW'(8) : '0;
                    if (empty_msg) begin
                        n_fin_cnt = 2'd0;
                        n_state   = ST_FIN;
                    end else if (!rem_ge8 || rem_eff == LenW'(8)) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (r_wic == '0) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_chunk_go && !r_f2_v) begin
                    n_fin_cnt = 2'd0;
                    n_state   = ST_FIN;
                end
            end
            ST_FIN: begin
                if (r_fin_cnt != 2'd3) begin
                    n_hash    = hash_round;
                    n_fin_cnt = r_fin_cnt + 2'd1;
                end else if (out_free) begin
                    n_hash  = hash_round;
                    n_out   = hash_round;
                    n_out_v = 1'b1;
                    n_wic   = 4'd0;
                    n_state = ST_RUN;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_remaining <= '0;
            r_wic       <= '0;
            r_chunk_go  <= 1'b0;
            r_f2_v      <= 1'b0;
            r_fin_cnt   <= '0;
            r_out_v     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_remaining <= n_remaining;
            r_wic       <= n_wic;
            r_chunk_go  <= n_chunk_go;
            r_f2_v      <= r_chunk_go;
            r_fin_cnt   <= n_fin_cnt;
            r_out_v     <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seed_high <= n_seed_high;
        r_hash      <= n_hash;
        r_fold      <= n_fold;
        r_half      <= n_half;
        r_out       <= n_out;
        if (r_chunk_go) begin
            r_f2 <= chunk_round;
        end
    end

    assign o_hash_valid = r_out_v;
    assign o_hash_low   = r_out[63:0];
    assign o_hash_high  = r_out[127:64];

endmodule

`default_nettype wire
